// ===== sv/dlv_pkg.sv =====
`default_nettype none
package dlv_pkg;

   localparam int unsigned DENS_W = 32;
   localparam int unsigned CORNERS = 4;
   localparam int unsigned ROWS_PER_CELL = 32;

   // Corner values after interpolation along y (4 * c0 + ys * dy).
   localparam int unsigned P_W = 35;
   // Row values after interpolation along x (8 * p0 + xs * dp).
   localparam int unsigned E_W = 38;
   // Voxel density times 256 after interpolation along z.
   localparam int unsigned S_W = 41;

   typedef struct packed {
      logic              cell_x;
      logic              cell_z;
      logic [4:0]        cell_y;
      logic signed [31:0] dens_x0_z0_y0;
      logic signed [31:0] dens_x0_z1_y0;
      logic signed [31:0] dens_x1_z0_y0;
      logic signed [31:0] dens_x1_z1_y0;
      logic signed [31:0] dens_x0_z0_y1;
      logic signed [31:0] dens_x0_z1_y1;
      logic signed [31:0] dens_x1_z0_y1;
      logic signed [31:0] dens_x1_z1_y1;
   } req_type;

   typedef struct packed {
      logic [14:0] row_start_index;
      logic [7:0]  solid_mask;
      logic [7:0]  fill_id;
      logic        last_row;
   } rsp_type;

   // One queued cell: low-y corners and the y deltas, indexed by x * 2 + z.
   typedef struct packed {
      logic                     cell_x;
      logic                     cell_z;
      logic [4:0]               cell_y;
      logic signed [3:0][31:0]  base;
      logic signed [3:0][32:0]  delta;
   } cell_entry_type;

endpackage
`default_nettype wire

// ===== sv/dlv_front.sv =====
`default_nettype none
module dlv_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire dlv_pkg::req_type        req_data,
   output logic                         head_valid,
   output dlv_pkg::cell_entry_type      head_entry,
   input  wire logic                    head_pop
);
   import dlv_pkg::*;

   localparam int unsigned DEPTH = 2;

   cell_entry_type slot_ff [DEPTH];
   cell_entry_type entry;
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           push;

   // Classify the cell: keep the low-y corners and the differences along y.
   always_comb begin
      entry.cell_x = req_data.cell_x;
      entry.cell_z = req_data.cell_z;
      entry.cell_y = req_data.cell_y;
      entry.base[0] = req_data.dens_x0_z0_y0;
      entry.base[1] = req_data.dens_x0_z1_y0;
      entry.base[2] = req_data.dens_x1_z0_y0;
      entry.base[3] = req_data.dens_x1_z1_y0;
      entry.delta[0] = 33'(req_data.dens_x0_z0_y1) - 33'(req_data.dens_x0_z0_y0);
      entry.delta[1] = 33'(req_data.dens_x0_z1_y1) - 33'(req_data.dens_x0_z1_y0);
      entry.delta[2] = 33'(req_data.dens_x1_z0_y1) - 33'(req_data.dens_x1_z0_y0);
      entry.delta[3] = 33'(req_data.dens_x1_z1_y1) - 33'(req_data.dens_x1_z1_y0);
   end

   assign req_stall  = (count_ff == 2'(DEPTH));
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != 2'd0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = head_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(head_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= entry;
      end
   end

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid)
      else $error("cell queue popped while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(DEPTH))
      else $error("cell queue count beyond depth");

   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'(DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("cell queue pointers disagree with count");

endmodule
`default_nettype wire

// ===== sv/dlv_back.sv =====
`default_nettype none
module dlv_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    head_valid,
   input  wire dlv_pkg::cell_entry_type head_entry,
   output logic                         head_pop,
   input  wire logic [7:0]              solid_block_id,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output dlv_pkg::rsp_type             rsp_data
);
   import dlv_pkg::*;

   logic        advance;
   logic [4:0]  row_ff, row_in;

   // Stage 1: y interpolation done.
   logic                          v1_ff;
   logic signed [P_W-1:0]         p_ff [CORNERS];
   logic signed [P_W-1:0]         p_in [CORNERS];
   logic [2:0]                    xs1_ff;
   logic [14:0]                   idx1_ff;
   logic                          last1_ff;

   // Stage 2: x interpolation done.
   logic                          v2_ff;
   logic signed [E_W-1:0]         e_ff [2];
   logic signed [E_W-1:0]         e_in [2];
   logic [14:0]                   idx2_ff;
   logic                          last2_ff;

   // Output register.
   logic        out_valid_ff;
   rsp_type     out_ff;
   logic [7:0]  mask_in;

   logic [1:0]  ys;
   logic [2:0]  xs;
   logic [14:0] idx0;

   assign advance  = !out_valid_ff || !rsp_stall;
   assign ys       = row_ff[4:3];
   assign xs       = row_ff[2:0];
   assign head_pop = advance && head_valid && (row_ff == 5'(ROWS_PER_CELL - 1));
   assign idx0     = {head_entry.cell_x, xs, head_entry.cell_z, 3'b000,
                      head_entry.cell_y, ys};

   always_comb begin
      row_in = row_ff;
      if (advance && head_valid) begin
         row_in = row_ff + 5'd1;
      end
   end

   // Elements of a packed array are unsigned, so the corners are re-signed here.
   always_comb begin
      for (int k = 0; k < CORNERS; k++) begin
         p_in[k] = (P_W'($signed(head_entry.base[k])) <<< 2)
                 + P_W'($signed(head_entry.delta[k])) * $signed({1'b0, ys});
      end
      for (int c = 0; c < 2; c++) begin
         e_in[c] = (E_W'(p_ff[c]) <<< 3)
                 + (E_W'(p_ff[2 + c]) - E_W'(p_ff[c])) * $signed({1'b0, xs1_ff});
      end
   end

   // Eight lanes along z; each lane's weight is a constant.
   always_comb begin
      logic signed [S_W-1:0] diff;
      logic signed [S_W-1:0] sum;
      diff = S_W'(e_ff[1]) - S_W'(e_ff[0]);
      for (int z = 0; z < 8; z++) begin
         sum = (S_W'(e_ff[0]) <<< 3) + diff * $signed(S_W'(z));
         mask_in[z] = !sum[S_W-1] && (sum != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         row_ff <= row_in;
         if (advance) begin
            v1_ff        <= head_valid;
            v2_ff        <= v1_ff;
            out_valid_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff                   <= p_in;
         xs1_ff                 <= xs;
         idx1_ff                <= idx0;
         last1_ff               <= (row_ff == 5'(ROWS_PER_CELL - 1));
         e_ff                   <= e_in;
         idx2_ff                <= idx1_ff;
         last2_ff               <= last1_ff;
         out_ff.row_start_index <= idx2_ff;
         out_ff.solid_mask      <= mask_in;
         out_ff.fill_id         <= solid_block_id;
         out_ff.last_row        <= last2_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_row_holds_when_empty: assert property (@(posedge clock) disable iff (reset)
      !head_valid |=> row_ff == $past(row_ff))
      else $error("row counter moved without a queued cell");

   a_last_row_position: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_row) |->
         (rsp_data.row_start_index[13:11] == 3'd7 && rsp_data.row_start_index[1:0] == 2'd3))
      else $error("last row flagged away from the cell's final row");

   a_pop_at_wrap: assert property (@(posedge clock) disable iff (reset)
      head_pop |=> row_ff == 5'd0)
      else $error("cell released before its row counter wrapped");

endmodule
`default_nettype wire

// ===== sv/density_lattice_voxelizer.sv =====
// Trilinear voxelizer for one coarse density cell. Each request transaction carries a
// cell position and eight signed corner densities; the block upsamples the cell to
// 8 (x) by 4 (y) by 8 (z) voxels and returns 32 response transactions, y step outer
// and x step inner, each a row of eight voxels along z with its chunk start index
// (later voxels of the row add 128), a solid mask, the fill id and a last-row flag
// on the 32nd row. A voxel is solid when its exactly computed density (eight guard
// bits, no rounding) is strictly above zero. The back end emits one row per clock
// while the response side does not stall, so a cell occupies it for its 32 rows;
// each row passes through the y stage, x stage and output registers in turn. A
// two-entry cell queue lets the front end accept the next cells while rows are
// being produced and while the response side stalls. The solid_block_id register
// resets to 121 and is written through the csr port, which is always ready; write
// it only while no cell is in flight.
`default_nettype none
module density_lattice_voxelizer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire dlv_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output dlv_pkg::rsp_type       rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [7:0]        csr_data
);
   import dlv_pkg::*;

   localparam logic [7:0] SOLID_ID_RESET = 8'd121;

   logic [7:0]     solid_block_id_ff, solid_block_id_in;
   logic           head_valid;
   logic           head_pop;
   cell_entry_type head_entry;

   // The register port never back-pressures; a write lands on the next edge.
   assign csr_ready = 1'b1;

   always_comb begin
      solid_block_id_in = solid_block_id_ff;
      if (csr_valid && csr_ready) begin
         solid_block_id_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         solid_block_id_ff <= SOLID_ID_RESET;
      end else begin
         solid_block_id_ff <= solid_block_id_in;
      end
   end

   // Front end: takes cells, derives the y deltas and queues them.
   dlv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .head_pop   (head_pop)
   );

   // Back end: walks the 32 rows of the head cell through the interpolation pipeline.
   dlv_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_entry     (head_entry),
      .head_pop       (head_pop),
      .solid_block_id (solid_block_id_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data)
   );

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import dlv_pkg::*;

   // Clock, reset and the three channels of the voxelizer. Every input starts at a
   // known value so that nothing is X before the first clock edge.
   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [7:0] csr_data = '0;

   // Cells waiting for the request driver, and the voxel rows that the accepted
   // cells must still produce, oldest first.
   req_type cells_to_send [$];
   rsp_type voxel_rows_due [$];

   // Our own copy of the solid_block_id register, updated after each write.
   logic [7:0] fill_code = 8'd121;

   int cells_queued = 0;
   int cells_accepted = 0;
   int mismatch_count = 0;
   int gap_left = 0;
   int stall_left = 0;
   int stall_length;
   bit steady_flow = 1'b0;
   rsp_type due_row;

   density_lattice_voxelizer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   // Each mismatch prints one line and is counted.
   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // Length of an idle stretch. Most stretches are empty or short and a few are
   // long; in steady-flow phases neither side ever idles.
   function automatic int pick_idle_length(input int empty_pct);
      int roll;
      if (steady_flow) return 0;
      roll = $urandom_range(0, 99);
      if (roll < empty_pct) return 0;
      if (roll < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 80);
   endfunction

   // Builds a cell from its position and its eight corners. Corner k sits at
   // y = k[2], x = k[1], z = k[0], the order of the density fields.
   function automatic req_type make_cell(input bit cx, input bit cz, input bit [4:0] cy,
                                         input logic [7:0][31:0] dens);
      req_type lattice_cell;
      lattice_cell.cell_x = cx;
      lattice_cell.cell_z = cz;
      lattice_cell.cell_y = cy;
      lattice_cell.dens_x0_z0_y0 = dens[0];
      lattice_cell.dens_x0_z1_y0 = dens[1];
      lattice_cell.dens_x1_z0_y0 = dens[2];
      lattice_cell.dens_x1_z1_y0 = dens[3];
      lattice_cell.dens_x0_z0_y1 = dens[4];
      lattice_cell.dens_x0_z1_y1 = dens[5];
      lattice_cell.dens_x1_z0_y1 = dens[6];
      lattice_cell.dens_x1_z1_y1 = dens[7];
      return lattice_cell;
   endfunction

   // Trilinear forecast of one cell. The density of every voxel, scaled by 256, is
   // the exact integer sum of corner * wy * wx * wz with wy in quarters and wx, wz
   // in eighths; only its sign matters, and zero is empty. Rows run y step outer
   // and x step inner, eight voxels along z in each row.
   function automatic void forecast_voxel_rows(input req_type lattice_cell);
      logic [7:0][31:0] dens;
      longint corner [8];
      longint wy [2];
      longint wx [2];
      longint wz [2];
      longint density;
      rsp_type row;
      dens = {lattice_cell.dens_x1_z1_y1, lattice_cell.dens_x1_z0_y1,
              lattice_cell.dens_x0_z1_y1, lattice_cell.dens_x0_z0_y1,
              lattice_cell.dens_x1_z1_y0, lattice_cell.dens_x1_z0_y0,
              lattice_cell.dens_x0_z1_y0, lattice_cell.dens_x0_z0_y0};
      for (int k = 0; k < 8; k++) corner[k] = longint'($signed(dens[k]));
      for (int ys = 0; ys < 4; ys++) begin
         wy[0] = 4 - ys;
         wy[1] = ys;
         for (int xs = 0; xs < 8; xs++) begin
            wx[0] = 8 - xs;
            wx[1] = xs;
            row.solid_mask = '0;
            for (int zs = 0; zs < 8; zs++) begin
               wz[0] = 8 - zs;
               wz[1] = zs;
               density = 0;
               for (int k = 0; k < 8; k++) begin
                  density += corner[k] * wy[k >> 2] * wx[(k >> 1) & 1] * wz[k & 1];
               end
               row.solid_mask[zs] = (density > 0);
            end
            row.row_start_index = 15'(((xs + int'(lattice_cell.cell_x) * 8) << 11) |
                                      ((int'(lattice_cell.cell_z) * 8) << 7) |
                                      (int'(lattice_cell.cell_y) * 4 + ys));
            row.fill_id = fill_code;
            row.last_row = (ys == 3 && xs == 7);
            voxel_rows_due.push_back(row);
         end
      end
   endfunction

   // Request driver. A new transaction is presented only once the previous one has
   // been taken, so a stalled payload never changes. After each cell the sender may
   // rest for a random number of cycles.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (cells_to_send.size() > 0) begin
            req_valid <= 1'b1;
            req_data <= cells_to_send.pop_front();
            gap_left <= pick_idle_length(55);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response stall generator. A stall run is drawn whenever the previous one ends,
   // so stalls can land on any row of a cell, the last row included.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         stall_length = pick_idle_length(65);
         rsp_stall <= (stall_length > 0);
         stall_left <= (stall_length > 0) ? stall_length - 1 : 0;
      end
   end

   // Monitor. Both channels are sampled at the clock edge, before any driver update
   // of that edge takes effect. An accepted request transaction adds its 32 rows to
   // the forecast; an accepted response transaction is checked against the oldest.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            forecast_voxel_rows(req_data);
            cells_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (voxel_rows_due.size() == 0) begin
               report_mismatch("row_start_index of a row nobody asked for",
                               int'(rsp_data.row_start_index), -1);
            end else begin
               due_row = voxel_rows_due.pop_front();
               if (rsp_data.row_start_index !== due_row.row_start_index) begin
                  report_mismatch("row_start_index", int'(rsp_data.row_start_index),
                                  int'(due_row.row_start_index));
               end
               if (rsp_data.solid_mask !== due_row.solid_mask) begin
                  report_mismatch($sformatf("solid_mask of row %0d",
                                            due_row.row_start_index),
                                  int'(rsp_data.solid_mask), int'(due_row.solid_mask));
               end
               if (rsp_data.fill_id !== due_row.fill_id) begin
                  report_mismatch("fill_id", int'(rsp_data.fill_id), int'(due_row.fill_id));
               end
               if (rsp_data.last_row !== due_row.last_row) begin
                  report_mismatch($sformatf("last_row of row %0d", due_row.row_start_index),
                                  int'(rsp_data.last_row), int'(due_row.last_row));
               end
            end
         end
      end
   end

   task automatic queue_cell(input req_type lattice_cell);
      cells_to_send.push_back(lattice_cell);
      cells_queued++;
   endtask

   // Waits until every queued cell has been accepted and every forecast row has
   // come back. The check runs on the falling edge, away from the driver updates.
   task automatic wait_until_drained();
      do @(negedge clock);
      while (cells_accepted != cells_queued || voxel_rows_due.size() != 0);
   endtask

   // Register writes happen only with the block drained, plus a margin for the
   // pipeline behind the last row.
   task automatic write_fill_code(input logic [7:0] code);
      wait_until_drained();
      repeat (20) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= code;
      do @(posedge clock);
      while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      fill_code = code;
   endtask

   // Random cell. Each cell picks one flavor for its corners: raw 32-bit words,
   // tiny values around zero (exact zeros and ties), moderate values of mixed sign
   // so that the zero crossing runs through the cell, or the representable extremes.
   function automatic req_type random_cell();
      logic [7:0][31:0] dens;
      int flavor;
      flavor = $urandom_range(0, 99);
      for (int k = 0; k < 8; k++) begin
         if (flavor < 30) begin
            dens[k] = $urandom;
         end else if (flavor < 55) begin
            dens[k] = int'($urandom_range(0, 16)) - 8;
         end else if (flavor < 85) begin
            dens[k] = int'($urandom_range(0, 400000)) - 200000;
         end else begin
            case ($urandom_range(0, 4))
               0: dens[k] = 32'h8000_0000;
               1: dens[k] = 32'h7FFF_FFFF;
               2: dens[k] = 32'h0000_0000;
               3: dens[k] = 32'h0000_0001;
               default: dens[k] = 32'hFFFF_FFFF;
            endcase
         end
      end
      return make_cell(1'($urandom), 1'($urandom), 5'($urandom), dens);
   endfunction

   task automatic queue_random_cells(input int count);
      for (int n = 0; n < count; n++) queue_cell(random_cell());
   endtask

   // Directed cells: uniform fields at zero (which must stay empty), the positive
   // and negative extremes and plus or minus one, a lone positive corner in each of
   // the eight positions, sign splits along y and x that cancel exactly at the
   // midpoint, a split along z between the two extremes, and a checkerboard.
   task automatic queue_directed_cells();
      logic [7:0][31:0] dens;
      queue_cell(make_cell(1'b0, 1'b0, 5'd0, {8{32'h0000_0000}}));
      queue_cell(make_cell(1'b1, 1'b1, 5'd31, {8{32'h7FFF_FFFF}}));
      queue_cell(make_cell(1'b1, 1'b0, 5'd17, {8{32'h8000_0000}}));
      queue_cell(make_cell(1'b0, 1'b1, 5'd5, {8{32'h0000_0001}}));
      queue_cell(make_cell(1'b1, 1'b1, 5'd10, {8{32'hFFFF_FFFF}}));
      for (int k = 0; k < 8; k++) begin
         dens = '0;
         dens[k] = 32'h0000_0001;
         queue_cell(make_cell(1'(k), 1'(k >> 1), 5'(k * 4 + 3), dens));
      end
      for (int k = 0; k < 8; k++) dens[k] = k[2] ? -32'sh0001_0000 : 32'sh0001_0000;
      queue_cell(make_cell(1'b0, 1'b1, 5'd21, dens));
      for (int k = 0; k < 8; k++) dens[k] = k[1] ? -32'sh0003_0000 : 32'sh0003_0000;
      queue_cell(make_cell(1'b1, 1'b0, 5'd2, dens));
      for (int k = 0; k < 8; k++) dens[k] = k[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
      queue_cell(make_cell(1'b0, 1'b0, 5'd30, dens));
      for (int k = 0; k < 8; k++) dens[k] = (k == 7) ? 32'h7FFF_FFFF : 32'h8000_0000;
      queue_cell(make_cell(1'b1, 1'b1, 5'd15, dens));
      for (int k = 0; k < 8; k++) dens[k] = ^k[2:0] ? -32'sd5000 : 32'sd5000;
      queue_cell(make_cell(1'b0, 1'b1, 5'd8, dens));
   endtask

   // Main sequence. The directed cells run with the reset value of the register;
   // after that each phase writes a new fill code, the extremes among them, and
   // sends random cells. One phase runs with no idling on either side, and one
   // phase pauses the sender mid-way until every forecast row has come back.
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      queue_directed_cells();

      write_fill_code(8'd0);
      queue_random_cells(35);
      wait_until_drained();
      queue_random_cells(35);

      write_fill_code(8'd255);
      steady_flow = 1'b1;
      queue_random_cells(30);
      wait_until_drained();
      steady_flow = 1'b0;
      queue_random_cells(45);

      write_fill_code(8'($urandom_range(1, 254)));
      queue_random_cells(70);

      write_fill_code(8'd121);
      queue_random_cells(65);

      wait_until_drained();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("density_lattice_voxelizer test passed");
      end else begin
         $display("density_lattice_voxelizer test failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run, even with every row held by the
   // longest stall.
   initial begin
      #20_000_000;
      $display("density_lattice_voxelizer test failed");
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
sv/dlv_pkg.sv
sv/dlv_front.sv
sv/dlv_back.sv
sv/density_lattice_voxelizer.sv
tb/testbench.sv
